@@ hw/rtl/bps_pkg.sv @@
`default_nettype none

package bps_pkg;

  localparam int unsigned CfgIdxW = 3;

  // Power state codes as reported on the result channel.
  localparam logic [2:0] ST_DISCONNECTED = 3'd0;
  localparam logic [2:0] ST_NORMAL       = 3'd1;
  localparam logic [2:0] ST_LOW          = 3'd2;
  localparam logic [2:0] ST_CRITICAL     = 3'd3;
  localparam logic [2:0] ST_SHUTDOWN     = 3'd4;
  localparam logic [2:0] ST_SENSOR_FAULT = 3'd5;
  localparam logic [2:0] ST_OVERTEMP     = 3'd6;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_CRIT_RUNTIME = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LOW_RUNTIME  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_HYSTERESIS   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_UNDERVOLTAGE = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MAX_TEMP     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_GRACE        = 3'd5;

  typedef struct packed {
    logic [15:0] critical_runtime_min;
    logic [15:0] low_runtime_min;
    logic [15:0] runtime_hysteresis_min;
    logic [15:0] undervoltage_mv;
    logic [14:0] temp_limit_cdeg;
    logic [31:0] crit_grace_ms;
  } cfg_t;

  typedef struct packed {
    logic               pack_attached;
    logic               reading_good;
    logic signed [15:0] pack_temp_cdeg;
    logic [15:0]        vbat_mv;
    logic [15:0]        runtime_min;
    logic [31:0]        time_ms;
  } sample_t;

  typedef struct packed {
    logic [2:0]  current_state;
    logic        shutdown_latch;
    logic        grace_timer_active;
    logic [31:0] critical_start_ms;
  } sup_state_t;

  typedef struct packed {
    logic [2:0] power_state;
    logic       mute_audio;
    logic       request_shutdown;
    logic       warn_critical;
    logic       reduce_load;
    logic       warn_low;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/bps_cfg_regs.sv @@
`default_nettype none

module bps_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [bps_pkg::CfgIdxW-1:0]   wr_index,
  input  wire logic [31:0]                   wr_data,
  output bps_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.critical_runtime_min   <= 16'd5;
      cfg.low_runtime_min        <= 16'd15;
      cfg.runtime_hysteresis_min <= 16'd2;
      cfg.undervoltage_mv        <= 16'd3000;
      cfg.temp_limit_cdeg        <= 15'd6000;
      cfg.crit_grace_ms          <= 32'd30000;
    end else if (wr_en) begin
      case (wr_index)
        bps_pkg::REG_CRIT_RUNTIME: cfg.critical_runtime_min   <= wr_data[15:0];
        bps_pkg::REG_LOW_RUNTIME:  cfg.low_runtime_min        <= wr_data[15:0];
        bps_pkg::REG_HYSTERESIS:   cfg.runtime_hysteresis_min <= wr_data[15:0];
        bps_pkg::REG_UNDERVOLTAGE: cfg.undervoltage_mv        <= wr_data[15:0];
        bps_pkg::REG_MAX_TEMP:     cfg.temp_limit_cdeg        <= wr_data[14:0];
        bps_pkg::REG_GRACE:        cfg.crit_grace_ms          <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bps_eval.sv @@
`default_nettype none

module bps_eval (
  input  wire bps_pkg::sample_t    sample,
  input  wire bps_pkg::cfg_t       cfg,
  input  wire bps_pkg::sup_state_t state,
  output bps_pkg::result_t         result,
  output bps_pkg::sup_state_t      state_next
);

  logic        over_temp;
  logic        under_volt;
  logic [15:0] crit_exit;
  logic [15:0] low_release;
  logic        crit;
  logic        low;
  logic [31:0] start_ms;
  logic [31:0] elapsed;
  logic        grace_expired;

  always_comb begin
    over_temp  = $signed({sample.pack_temp_cdeg[15], sample.pack_temp_cdeg})
                 >= $signed({2'b00, cfg.temp_limit_cdeg});
    under_volt = sample.vbat_mv <= cfg.undervoltage_mv;

    // Exit thresholds wrap modulo 2^16, as the arithmetic is kept at 16 bits.
    crit_exit   = cfg.critical_runtime_min + cfg.runtime_hysteresis_min;
    low_release = cfg.low_runtime_min + cfg.runtime_hysteresis_min;
    crit = (sample.runtime_min <= cfg.critical_runtime_min) ||
           (state.current_state == bps_pkg::ST_CRITICAL && sample.runtime_min < crit_exit);
    low  = (sample.runtime_min <= cfg.low_runtime_min) ||
           (state.current_state == bps_pkg::ST_LOW && sample.runtime_min < low_release);

    start_ms      = state.grace_timer_active ? state.critical_start_ms : sample.time_ms;
    elapsed       = sample.time_ms - start_ms;
    grace_expired = elapsed >= cfg.crit_grace_ms;
  end

  always_comb begin
    state_next = state;
    result     = '0;
    result.mute_audio       = 1'b1;
    result.request_shutdown = 1'b1;

    if (!sample.pack_attached) begin
      state_next.shutdown_latch     = 1'b0;
      state_next.grace_timer_active = 1'b0;
      result.power_state            = bps_pkg::ST_DISCONNECTED;
    end else if (state.shutdown_latch) begin
      result.power_state = bps_pkg::ST_SHUTDOWN;
    end else if (!sample.reading_good) begin
      state_next.shutdown_latch = 1'b1;
      result.power_state        = bps_pkg::ST_SENSOR_FAULT;
    end else if (over_temp) begin
      state_next.shutdown_latch = 1'b1;
      result.power_state        = bps_pkg::ST_OVERTEMP;
    end else if (under_volt) begin
      state_next.shutdown_latch = 1'b1;
      result.power_state        = bps_pkg::ST_SHUTDOWN;
    end else if (crit) begin
      state_next.grace_timer_active = 1'b1;
      state_next.critical_start_ms  = start_ms;
      result.warn_critical          = 1'b1;
      if (grace_expired) begin
        state_next.shutdown_latch = 1'b1;
        result.power_state        = bps_pkg::ST_SHUTDOWN;
      end else begin
        result.power_state      = bps_pkg::ST_CRITICAL;
        result.mute_audio       = 1'b0;
        result.request_shutdown = 1'b0;
        result.reduce_load      = 1'b1;
      end
    end else begin
      state_next.grace_timer_active = 1'b0;
      result.mute_audio             = 1'b0;
      result.request_shutdown       = 1'b0;
      if (low) begin
        result.power_state = bps_pkg::ST_LOW;
        result.warn_low    = 1'b1;
      end else begin
        result.power_state = bps_pkg::ST_NORMAL;
      end
    end

    state_next.current_state = result.power_state;
  end

endmodule

`default_nettype wire

@@ hw/rtl/battery_power_supervisor_unit.sv @@
// Battery power supervisor.
// Samples arrive on the in_valid/in_ready channel, one request per battery
// sample, and each gives exactly one result on out_valid/out_ready: the new
// power state and the mute, shutdown, warning and load-reduction flags.
// Thresholds are set through the cfg_valid/cfg_ready write channel, which is
// always ready; cfg_index selects the register and indexes above the last
// register are ignored. Write it only while no request is in flight.
// A sample is captured in an input register, decided by one level of compare
// and subtract logic against the stored supervisor state, and the result is
// held in an output register. out_valid rises once the decision stage moves
// the sample into a free output register; one sample per cycle is sustained
// while out_ready holds high, and each state update feeds the next decision.
// Reset restores the default thresholds, clears the shutdown latch and grace
// timer and sets the state to disconnected. When the receiver stalls, the
// output register and the input register hold their requests and in_ready
// falls once both are full, so nothing is lost or repeated.
`default_nettype none

module battery_power_supervisor_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic [bps_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [31:0]                  cfg_data,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire logic                         pack_attached,
  input  wire logic                         reading_good,
  input  wire logic signed [15:0]           pack_temp_cdeg,
  input  wire logic [15:0]                  vbat_mv,
  input  wire logic [15:0]                  runtime_min,
  input  wire logic [31:0]                  time_ms,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      logic [2:0]                   power_state,
  output      logic                         mute_audio,
  output      logic                         request_shutdown,
  output      logic                         warn_critical,
  output      logic                         reduce_load,
  output      logic                         warn_low
);

  bps_pkg::cfg_t       cfg;
  bps_pkg::sample_t    s1;
  logic                s1_valid;
  bps_pkg::sup_state_t state;
  bps_pkg::sup_state_t state_next;
  bps_pkg::result_t    res_next;
  bps_pkg::result_t    res;
  logic                advance;

  assign cfg_ready = 1'b1;

  bps_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The decision stage moves only when the output register is free.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1.pack_attached  <= pack_attached;
      s1.reading_good   <= reading_good;
      s1.pack_temp_cdeg <= pack_temp_cdeg;
      s1.vbat_mv        <= vbat_mv;
      s1.runtime_min    <= runtime_min;
      s1.time_ms        <= time_ms;
    end
  end

  bps_eval u_eval (
    .sample     (s1),
    .cfg        (cfg),
    .state      (state),
    .result     (res_next),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.current_state      <= bps_pkg::ST_DISCONNECTED;
      state.shutdown_latch     <= 1'b0;
      state.grace_timer_active <= 1'b0;
      state.critical_start_ms  <= 32'd0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign power_state      = res.power_state;
  assign mute_audio       = res.mute_audio;
  assign request_shutdown = res.request_shutdown;
  assign warn_critical    = res.warn_critical;
  assign reduce_load      = res.reduce_load;
  assign warn_low         = res.warn_low;

  // A missing pack always clears the latch and the grace timer.
  assert property (@(posedge clk) disable iff (rst)
    (advance && !s1.pack_attached) |=> (!state.shutdown_latch && !state.grace_timer_active))
    else $error("latch or timer survived a missing pack");

  // A critical result never asks for shutdown and always warns.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && power_state == bps_pkg::ST_CRITICAL)
      |-> (warn_critical && reduce_load && !request_shutdown && !mute_audio))
    else $error("critical result carries wrong flags");

  // While the latch is set and the pack stays, every result is shutdown.
  assert property (@(posedge clk) disable iff (rst)
    (advance && state.shutdown_latch && s1.pack_attached)
      |=> (out_valid && power_state == bps_pkg::ST_SHUTDOWN && state.shutdown_latch))
    else $error("latched shutdown not reported");

  // The input side is only held off while a sample waits in the input register behind a stalled result.
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled without cause");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AT_SAMPLE = 400;
  localparam int HOLD_CYCLES = 120;

  // Indexes past the last register; writes to them must leave everything alone.
  localparam logic [bps_pkg::CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [bps_pkg::CfgIdxW-1:0] REG_SPARE_HI = 3'd7;

  localparam bps_pkg::result_t R_NONE = '0;
  localparam bps_pkg::result_t R_GONE =
    '{bps_pkg::ST_DISCONNECTED, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
  localparam bps_pkg::result_t R_FAULT =
    '{bps_pkg::ST_SENSOR_FAULT, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
  localparam bps_pkg::result_t R_HOT = '{bps_pkg::ST_OVERTEMP, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
  localparam bps_pkg::result_t R_OFF = '{bps_pkg::ST_SHUTDOWN, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
  localparam bps_pkg::result_t R_OK = '{bps_pkg::ST_NORMAL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam bps_pkg::result_t R_LOW = '{bps_pkg::ST_LOW, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
  localparam bps_pkg::result_t R_CRIT = '{bps_pkg::ST_CRITICAL, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

  typedef struct {
    bps_pkg::sample_t smp;
    bit               typed;
    bps_pkg::result_t res;
  } row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [bps_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [31:0]       cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              pack_attached = 1'b0;
  logic              reading_good = 1'b0;
  logic signed [15:0] pack_temp_cdeg = '0;
  logic [15:0]       vbat_mv = '0;
  logic [15:0]       runtime_min = '0;
  logic [31:0]       time_ms = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        power_state;
  logic              mute_audio;
  logic              request_shutdown;
  logic              warn_critical;
  logic              reduce_load;
  logic              warn_low;

  // Travels alongside the payload so the monitor knows which rows carry a fixed answer.
  logic              row_typed = 1'b0;
  bps_pkg::result_t  row_expect = '0;

  battery_power_supervisor_unit uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .pack_attached(pack_attached), .reading_good(reading_good),
    .pack_temp_cdeg(pack_temp_cdeg), .vbat_mv(vbat_mv),
    .runtime_min(runtime_min), .time_ms(time_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .power_state(power_state), .mute_audio(mute_audio), .request_shutdown(request_shutdown),
    .warn_critical(warn_critical), .reduce_load(reduce_load), .warn_low(warn_low)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Supervisor model: thresholds and state.
  logic [15:0] crit_q = 16'd5;
  logic [15:0] low_q = 16'd15;
  logic [15:0] hyst_q = 16'd2;
  logic [15:0] uv_q = 16'd3000;
  logic [14:0] max_temp_q = 15'd6000;
  logic [31:0] grace_q = 32'd30000;
  logic [2:0]  state_q = bps_pkg::ST_DISCONNECTED;
  logic        latch_q = 1'b0;
  logic        timer_on_q = 1'b0;
  logic [31:0] start_q = '0;

  bps_pkg::result_t expected_results[$];
  row_t    directed_rows[$];
  bps_pkg::cfg_t settings[$];
  int      n_sent = 0;
  int      n_checked = 0;
  int      n_fail = 0;
  int      cycle_count = 0;
  int      state_hits[8];
  bit      sender_calm = 1'b0;
  logic [31:0] stamp_ms = '0;

  function automatic bps_pkg::result_t supervise(input bps_pkg::sample_t s);
    bps_pkg::result_t r;
    logic [15:0] crit_exit;
    logic [15:0] low_release;
    logic [31:0] elapsed;
    r = '0;
    if (!s.pack_attached) begin
      latch_q = 1'b0;
      timer_on_q = 1'b0;
      r = R_GONE;
    end else if (latch_q) begin
      r = R_OFF;
    end else if (!s.reading_good) begin
      latch_q = 1'b1;
      r = R_FAULT;
    end else if ($signed({s.pack_temp_cdeg[15], s.pack_temp_cdeg}) >=
                 $signed({2'b00, max_temp_q})) begin
      latch_q = 1'b1;
      r = R_HOT;
    end else if (s.vbat_mv <= uv_q) begin
      latch_q = 1'b1;
      r = R_OFF;
    end else begin
      crit_exit = crit_q + hyst_q;
      if (s.runtime_min <= crit_q ||
          (state_q == bps_pkg::ST_CRITICAL && s.runtime_min < crit_exit)) begin
        if (!timer_on_q) begin
          start_q = s.time_ms;
          timer_on_q = 1'b1;
        end
        elapsed = s.time_ms - start_q;
        if (elapsed >= grace_q) begin
          latch_q = 1'b1;
          r = R_OFF;
          r.warn_critical = 1'b1;
        end else begin
          r = R_CRIT;
        end
      end else begin
        timer_on_q = 1'b0;
        low_release = low_q + hyst_q;
        if (s.runtime_min <= low_q ||
            (state_q == bps_pkg::ST_LOW && s.runtime_min < low_release)) begin
          r = R_LOW;
        end else begin
          r = R_OK;
        end
      end
    end
    state_q = r.power_state;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [2:0] want, input logic [2:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      n_fail++;
    end
  endtask

  // Results are compared before new requests are predicted, all on pre-edge values.
  always @(posedge clk) begin : monitor
    bps_pkg::result_t got;
    bps_pkg::result_t want;
    bps_pkg::sample_t smp;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{power_state, mute_audio, request_shutdown, warn_critical, reduce_load,
                warn_low};
        state_hits[got.power_state]++;
        if (expected_results.size() == 0) begin
          $error("result with no sample waiting for it: state %0d", got.power_state);
          n_fail++;
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          check_field("power_state", want.power_state, got.power_state);
          check_field("mute_audio", 3'(want.mute_audio), 3'(got.mute_audio));
          check_field("request_shutdown", 3'(want.request_shutdown),
                      3'(got.request_shutdown));
          check_field("warn_critical", 3'(want.warn_critical), 3'(got.warn_critical));
          check_field("reduce_load", 3'(want.reduce_load), 3'(got.reduce_load));
          check_field("warn_low", 3'(want.warn_low), 3'(got.warn_low));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bps_pkg::REG_CRIT_RUNTIME: crit_q = cfg_data[15:0];
          bps_pkg::REG_LOW_RUNTIME:  low_q = cfg_data[15:0];
          bps_pkg::REG_HYSTERESIS:   hyst_q = cfg_data[15:0];
          bps_pkg::REG_UNDERVOLTAGE: uv_q = cfg_data[15:0];
          bps_pkg::REG_MAX_TEMP:     max_temp_q = cfg_data[14:0];
          bps_pkg::REG_GRACE:        grace_q = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        smp = '{pack_attached, reading_good, pack_temp_cdeg, vbat_mv, runtime_min,
                time_ms};
        want = supervise(smp);
        if (row_typed) want = row_expect;
        expected_results.push_back(want);
      end
    end
  end

  // Result side: random stalls, calm stretches, and one long hold-off that lets
  // the block fill up while samples keep coming.
  int  stall_left = 0;
  bit  hold_done = 1'b0;
  bit  sink_calm = 1'b0;

  always @(posedge clk) begin
    if (!hold_done && n_sent >= HOLD_AT_SAMPLE) begin
      hold_done = 1'b1;
      stall_left = HOLD_CYCLES;
    end
    if ($urandom_range(0, 199) == 0) sink_calm = !sink_calm;
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (sink_calm || $urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 2);
    end
  end

  function automatic bps_pkg::sample_t mk_sample(input bit pp, input bit ok, input int temp,
                                                 input int mv, input int rt,
                                                 input logic [31:0] t);
    bps_pkg::sample_t s;
    s.pack_attached = pp;
    s.reading_good = ok;
    s.pack_temp_cdeg = temp[15:0];
    s.vbat_mv = mv[15:0];
    s.runtime_min = rt[15:0];
    s.time_ms = t;
    return s;
  endfunction

  task automatic add_row(input bps_pkg::sample_t s, input bit typed,
                         input bps_pkg::result_t res);
    row_t r;
    r.smp = s;
    r.typed = typed;
    r.res = res;
    directed_rows.push_back(r);
  endtask

  // Mostly healthy samples with runtime close to the thresholds and time moving
  // forward, so that hysteresis and the grace timer get exercised.
  function automatic bps_pkg::sample_t draw_sample();
    bps_pkg::sample_t s;
    logic [15:0] base;
    int pick;
    pick = $urandom_range(0, 99);
    s.pack_attached = 1'b1;
    s.reading_good = 1'b1;
    s.pack_temp_cdeg = 16'($urandom_range(0, int'(max_temp_q) + 32767) - 32768);
    if (uv_q == 16'hFFFF) s.vbat_mv = 16'($urandom);
    else s.vbat_mv = 16'($urandom_range(int'(uv_q) + 1, 65535));
    case ($urandom_range(0, 4))
      0, 1: base = crit_q;
      2, 3: base = low_q;
      default: base = 16'($urandom);
    endcase
    if ($urandom_range(0, 1) == 1) base = base + hyst_q;
    s.runtime_min = base + 16'($urandom_range(0, 6)) - 16'd3;
    if ($urandom_range(0, 19) == 0) stamp_ms = $urandom;
    else stamp_ms = stamp_ms + $urandom_range(0, grace_q / 3 + 1);
    s.time_ms = stamp_ms;
    // A latched supervisor only recovers through a pack removal, so offer more of them.
    if (latch_q ? pick < 25 : pick < 6) begin
      s.pack_attached = 1'b0;
      s.reading_good = 1'($urandom_range(0, 1));
    end else if (pick >= 94 && pick < 96) begin
      s.reading_good = 1'b0;
    end else if (pick >= 96 && pick < 98) begin
      s.pack_temp_cdeg = 16'($urandom_range(int'(max_temp_q), 32767));
    end else if (pick >= 98) begin
      s.vbat_mv = 16'($urandom_range(0, int'(uv_q)));
    end
    return s;
  endfunction

  task automatic send_sample(input bps_pkg::sample_t s, input bit typed,
                             input bps_pkg::result_t res);
    int gap;
    int r;
    if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
    r = $urandom_range(0, 99);
    if (sender_calm || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pack_attached <= s.pack_attached;
    reading_good <= s.reading_good;
    pack_temp_cdeg <= s.pack_temp_cdeg;
    vbat_mv <= s.vbat_mv;
    runtime_min <= s.runtime_min;
    time_ms <= s.time_ms;
    row_typed <= typed;
    row_expect <= res;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  // Stop offering requests and let every outstanding result come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (n_checked < n_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bps_pkg::CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Upper data bits are junk on purpose: only the register's own width counts.
  task automatic load_thresholds(input bps_pkg::cfg_t c);
    write_reg(REG_SPARE_HI, $urandom);
    write_reg(bps_pkg::REG_CRIT_RUNTIME, {16'($urandom), c.critical_runtime_min});
    write_reg(bps_pkg::REG_LOW_RUNTIME, {16'($urandom), c.low_runtime_min});
    write_reg(bps_pkg::REG_HYSTERESIS, {16'($urandom), c.runtime_hysteresis_min});
    write_reg(bps_pkg::REG_UNDERVOLTAGE, {16'($urandom), c.undervoltage_mv});
    write_reg(bps_pkg::REG_MAX_TEMP, {17'($urandom), c.temp_limit_cdeg});
    write_reg(bps_pkg::REG_GRACE, c.crit_grace_ms);
    write_reg(REG_SPARE_LO, $urandom);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    bps_pkg::cfg_t c;
    int lo;
    int n_items;

    // Directed rows run on the reset thresholds: critical 5, low 15, hysteresis 2,
    // undervoltage 3000, temperature limit 6000, grace 30000.
    add_row(mk_sample(0, 1, 2500, 3700, 60, 0), 1, R_GONE);
    add_row(mk_sample(1, 0, 2500, 3700, 60, 10), 1, R_FAULT);
    add_row(mk_sample(1, 1, 2500, 3700, 60, 20), 1, R_OFF);
    add_row(mk_sample(0, 0, 0, 0, 0, 30), 1, R_GONE);
    add_row(mk_sample(1, 1, 6000, 3700, 60, 40), 1, R_HOT);
    add_row(mk_sample(0, 1, 32767, 65535, 65535, 32'hFFFF_FFFF), 1, R_GONE);
    add_row(mk_sample(1, 1, -32768, 3000, 60, 50), 1, R_OFF);
    add_row(mk_sample(0, 1, 2500, 3700, 60, 60), 1, R_GONE);
    add_row(mk_sample(1, 1, 5999, 3001, 65535, 70), 1, R_OK);
    add_row(mk_sample(1, 1, -1, 65535, 15, 80), 1, R_LOW);
    add_row(mk_sample(1, 1, 0, 4000, 16, 90), 0, R_NONE);
    add_row(mk_sample(1, 1, 0, 4000, 17, 100), 0, R_NONE);
    add_row(mk_sample(1, 1, 0, 4000, 5, 100), 1, R_CRIT);
    add_row(mk_sample(1, 1, 0, 4000, 6, 200), 0, R_NONE);
    add_row(mk_sample(1, 1, 0, 4000, 0, 30099), 0, R_NONE);
    add_row(mk_sample(1, 1, 0, 4000, 0, 30100), 0, R_NONE);
    add_row(mk_sample(0, 1, 0, 4000, 0, 30200), 1, R_GONE);
    // Grace timer started just before the timestamp wraps.
    add_row(mk_sample(1, 1, 0, 4000, 5, 32'hFFFF_FF00), 1, R_CRIT);
    add_row(mk_sample(1, 1, 0, 4000, 6, 32'h0000_7400), 0, R_NONE);
    add_row(mk_sample(1, 1, 0, 4000, 1, 32'h0000_7430), 0, R_NONE);
    add_row(mk_sample(1, 1, 0, 4000, 1, 32'h0000_8000), 1, R_OFF);
    add_row(mk_sample(0, 1, 0, 4000, 1, 0), 1, R_GONE);
    add_row(mk_sample(1, 1, 0, 4000, 7, 10), 0, R_NONE);
    add_row(mk_sample(1, 1, 0, 0, 65535, 20), 1, R_OFF);
    add_row(mk_sample(0, 0, 0, 0, 0, 0), 1, R_GONE);

    // Threshold settings for the random part: both extremes, values below the
    // legal range, and exit thresholds that wrap round 16 bits.
    c = '{16'd1, 16'd2, 16'd1, 16'd1, 15'd32767, 32'd1};
    settings.push_back(c);
    c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'd1, 32'hFFFF_FFFF};
    settings.push_back(c);
    c = '{16'd0, 16'd0, 16'd0, 16'd0, 15'd0, 32'd0};
    settings.push_back(c);
    c = '{16'd65530, 16'd40000, 16'd10, 16'd2000, 15'd20000, 32'd5000};
    settings.push_back(c);
    c = '{16'd100, 16'd65530, 16'd20, 16'd3300, 15'd4500, 32'd2000};
    settings.push_back(c);
    c = '{16'd5, 16'd15, 16'd2, 16'd3000, 15'd6000, 32'd30000};
    settings.push_back(c);
    lo = $urandom_range(1, 2000);
    c.critical_runtime_min = 16'(lo);
    c.low_runtime_min = 16'(lo + $urandom_range(1, 2000));
    c.runtime_hysteresis_min = 16'($urandom_range(1, 100));
    c.undervoltage_mv = 16'($urandom_range(2500, 3500));
    c.temp_limit_cdeg = 15'($urandom_range(1, 32767));
    c.crit_grace_ms = $urandom_range(1, 100000);
    settings.push_back(c);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].res);
    end

    for (int p = 0; p < settings.size(); p++) begin
      wait_idle();
      load_thresholds(settings[p]);
      // Every valid sample trips undervoltage in the high-extremes setting, so keep it short.
      n_items = (p == 1) ? 60 : 145;
      for (int i = 0; i < n_items; i++) begin
        if (p == 4 && i == 70) wait_idle();
        send_sample(draw_sample(), 1'b0, R_NONE);
      end
    end
    wait_idle();

    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      n_fail++;
    end
    $display("summary: %0d samples (%0d directed) over %0d threshold settings, %0d compared",
             n_sent, directed_rows.size(), settings.size() + 1, n_checked);
    $display({"summary: disconnected %0d normal %0d low %0d critical %0d",
              " shutdown %0d fault %0d hot %0d"},
             state_hits[bps_pkg::ST_DISCONNECTED], state_hits[bps_pkg::ST_NORMAL],
             state_hits[bps_pkg::ST_LOW], state_hits[bps_pkg::ST_CRITICAL],
             state_hits[bps_pkg::ST_SHUTDOWN], state_hits[bps_pkg::ST_SENSOR_FAULT],
             state_hits[bps_pkg::ST_OVERTEMP]);
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
hw/rtl/bps_pkg.sv
hw/rtl/bps_cfg_regs.sv
hw/rtl/bps_eval.sv
hw/rtl/battery_power_supervisor_unit.sv
test/testbench.sv
